FILE: design/htn_pkg.sv
// ----------------------------------------------------------------------------
// Height to normal map: shared constants
// Widths of the fixed-point words that pass between the pipeline sections.
// ----------------------------------------------------------------------------
package htn_pkg;

    // Normalised vector component magnitude (most significant one at bit 30).
    localparam int MAG_W  = 31;
    // Sum of three squared components.
    localparam int RAD_W  = 64;
    // Integer square root of the radicand.
    localparam int ROOT_W = 32;
    // Divider numerator, 65536 * magnitude + root.
    localparam int NUM_W  = 48;
    // Divider denominator, twice the root.
    localparam int DEN_W  = 33;
    // Quotient, at most 32768.
    localparam int QUO_W  = 16;

endpackage

FILE: design/htn_sqrt.sv
// ----------------------------------------------------------------------------
// Height to normal map: pipelined integer square root
// One result bit per stage, floor of the square root of a 64-bit radicand.
// ----------------------------------------------------------------------------
module htn_sqrt (
    input  logic                       aclk,
    input  logic                       ce,
    input  logic [htn_pkg::RAD_W-1:0]  rad_in,
    output logic [htn_pkg::ROOT_W-1:0] root_out
);

    localparam int STAGES = htn_pkg::ROOT_W;

    logic [htn_pkg::RAD_W-1:0]  rem_reg  [STAGES];
    logic [htn_pkg::ROOT_W-1:0] root_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int I = STAGES - 1 - k;

        logic [htn_pkg::RAD_W-1:0]  rem_in;
        logic [htn_pkg::ROOT_W-1:0] root_in;
        logic [htn_pkg::RAD_W:0]    trial;
        logic                       take;

        if (k == 0) begin : g_first
            assign rem_in  = rad_in;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 4^i; the two terms never overlap.
        assign trial = ({{(htn_pkg::RAD_W+1-htn_pkg::ROOT_W){1'b0}}, root_in} << (I + 1))
                     | ({{htn_pkg::RAD_W{1'b0}}, 1'b1} << (2 * I));
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (take) begin
                    rem_reg[k]  <= rem_in - trial[htn_pkg::RAD_W-1:0];
                    root_reg[k] <= root_in | (htn_pkg::ROOT_W'(1) << I);
                end else begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign root_out = root_reg[STAGES-1];

endmodule

FILE: design/htn_div.sv
// ----------------------------------------------------------------------------
// Height to normal map: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module htn_div (
    input  logic                      aclk,
    input  logic                      ce,
    input  logic [htn_pkg::NUM_W-1:0] num_in,
    input  logic [htn_pkg::DEN_W-1:0] den_in,
    output logic [htn_pkg::QUO_W-1:0] quo_out
);

    localparam int STAGES = htn_pkg::QUO_W;
    localparam int CMP_W  = htn_pkg::NUM_W + 1;

    logic [htn_pkg::NUM_W-1:0] rem_reg [STAGES];
    logic [htn_pkg::DEN_W-1:0] den_reg [STAGES];
    logic [htn_pkg::QUO_W-1:0] quo_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int I = STAGES - 1 - k;

        logic [htn_pkg::NUM_W-1:0] rem_in;
        logic [htn_pkg::DEN_W-1:0] den_in_k;
        logic [htn_pkg::QUO_W-1:0] quo_in;
        logic [CMP_W-1:0]          sub;
        logic                      take;

        if (k == 0) begin : g_first
            assign rem_in   = num_in;
            assign den_in_k = den_in;
            assign quo_in   = '0;
        end else begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign den_in_k = den_reg[k-1];
            assign quo_in   = quo_reg[k-1];
        end

        assign sub  = {{(CMP_W-htn_pkg::DEN_W){1'b0}}, den_in_k} << I;
        assign take = {1'b0, rem_in} >= sub;

        always_ff @(posedge aclk) begin
            if (ce) begin
                den_reg[k] <= den_in_k;
                if (take) begin
                    rem_reg[k] <= rem_in - sub[htn_pkg::NUM_W-1:0];
                    quo_reg[k] <= quo_in | (htn_pkg::QUO_W'(1) << I);
                end else begin
                    rem_reg[k] <= rem_in;
                    quo_reg[k] <= quo_in;
                end
            end
        end
    end

    assign quo_out = quo_reg[STAGES-1];

endmodule

FILE: design/height_to_normal_map.sv
// ----------------------------------------------------------------------------
// Height to normal map
// Turns a pixel height and two neighbour heights into a normal-map colour.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid / s_ready) carries one pixel per transaction: the
// centre height, the horizontal and vertical neighbour heights (signed Q15.16)
// and two flags saying the pixel sits in the last column or last row, in which
// case the neighbour lies to the left or below. The output channel
// (m_valid / m_ready) returns one transaction per pixel holding the unit
// normal remapped to three unsigned 16-bit colour channels.
// The grid spacing is written through cfg_we / cfg_wdata while the block is
// idle; reset loads 131072 / MAP_SIZE.
// Throughput is one pixel per clock while the receiver keeps up. A pixel
// passes from acceptance to m_valid through five front-end stages (difference,
// leading-one search, normalising shift, squaring, sum), 32 square-root
// stages, one numerator stage, 16 divider stages and the output register,
// the first of these 55 registers being loaded at the accepting edge. Reset
// clears every valid bit, the output's too. When the receiver stalls, a
// result waits in the output register; the pipeline keeps moving while its
// last stage is empty, and stops as a whole only once a second result is
// ready behind the waiting one, at which point s_ready drops.
// ----------------------------------------------------------------------------
module height_to_normal_map #(
    parameter int MAP_SIZE = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_height_center,
    input  logic [31:0] s_height_horizontal,
    input  logic [31:0] s_height_vertical,
    input  logic        s_at_last_column,
    input  logic        s_at_last_row,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_normal_red,
    output logic [15:0] m_normal_green,
    output logic [15:0] m_normal_blue
);

    localparam int MAG_W  = htn_pkg::MAG_W;
    localparam int RAD_W  = htn_pkg::RAD_W;
    localparam int ROOT_W = htn_pkg::ROOT_W;
    localparam int NUM_W  = htn_pkg::NUM_W;
    localparam int DEN_W  = htn_pkg::DEN_W;
    localparam int QUO_W  = htn_pkg::QUO_W;

    localparam logic [16:0] SPACING_RESET = 17'(131072 / MAP_SIZE);

    // Stage bookkeeping: five front stages, the square root, the numerator
    // stage and the divider.
    localparam int FRONT  = 5;
    localparam int SQ_LAT = ROOT_W;
    localparam int DV_LAT = QUO_W;
    localparam int NV     = FRONT + SQ_LAT + 1 + DV_LAT;
    localparam int V_SQ   = FRONT + SQ_LAT - 1;
    localparam int V_NUM  = FRONT + SQ_LAT;

    // Position that the leading one of the largest component is moved to.
    localparam logic [5:0] TARGET_MSB = 6'd30;

    logic [16:0] spacing_reg;

    logic          ce;
    logic [NV-1:0] vld_reg;
    logic          v_last;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= SPACING_RESET;
        end else if (cfg_we) begin
            spacing_reg <= cfg_wdata;
        end
    end

    // The whole pipeline advances together. It may move when the output
    // register is free or being emptied, or when its last stage holds a
    // bubble, so a waiting result never blocks the stages behind it early.
    assign v_last  = vld_reg[NV-1];
    assign ce      = m_ready || !m_valid || !v_last;
    assign s_ready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NV-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: neighbour differences, signs and magnitudes.
    // The direction is (-sx*dx, -sy*dy, s); a negative red channel occurs
    // when the horizontal slope points along the walk direction, and blue
    // is the negated y component.
    // ------------------------------------------------------------------
    logic signed [32:0] dx, dy;
    logic [32:0] mx1_reg, my1_reg;
    logic [16:0] mz1_reg;
    logic        negx1_reg, negy1_reg;

    assign dx = {s_height_horizontal[31], s_height_horizontal}
              - {s_height_center[31], s_height_center};
    assign dy = {s_height_vertical[31], s_height_vertical}
              - {s_height_center[31], s_height_center};

    always_ff @(posedge aclk) begin
        if (ce) begin
            mx1_reg   <= dx[32] ? 33'(-dx) : 33'(dx);
            my1_reg   <= dy[32] ? 33'(-dy) : 33'(dy);
            mz1_reg   <= (spacing_reg == 17'd0) ? 17'd1 : spacing_reg;
            negx1_reg <= s_at_last_column ? dx[32] : (!dx[32] && dx != 33'sd0);
            // Blue is negative unless the y component is negative or zero.
            negy1_reg <= (s_at_last_row ? !dy[32] : dy[32]) && dy != 33'sd0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: find the leading one of the largest magnitude.
    // ------------------------------------------------------------------
    logic [32:0] big;
    logic [5:0]  msb;
    logic [32:0] mx2_reg, my2_reg;
    logic [16:0] mz2_reg;
    logic [5:0]  msb2_reg;
    logic        negx2_reg, negy2_reg;

    always_comb begin
        big = mx1_reg;
        if (my1_reg > big) begin
            big = my1_reg;
        end
        if ({16'd0, mz1_reg} > big) begin
            big = {16'd0, mz1_reg};
        end
        msb = '0;
        for (int b = 0; b < 33; b++) begin
            if (big[b]) begin
                msb = 6'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mx2_reg   <= mx1_reg;
            my2_reg   <= my1_reg;
            mz2_reg   <= mz1_reg;
            msb2_reg  <= msb;
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: shift all three so the largest has its top bit at 30.
    // Right shifts truncate, as the bits shifted out are dropped.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mx3_reg, my3_reg, mz3_reg;
    logic             negx3_reg, negy3_reg;

    function automatic logic [MAG_W-1:0] norm_shift(input logic [32:0] v,
                                                    input logic [5:0]  p);
        logic [63:0] wide;
        begin
            if (p > TARGET_MSB) begin
                wide = {31'd0, v} >> (p - TARGET_MSB);
            end else begin
                wide = {31'd0, v} << (TARGET_MSB - p);
            end
            return wide[MAG_W-1:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            mx3_reg   <= norm_shift(mx2_reg, msb2_reg);
            my3_reg   <= norm_shift(my2_reg, msb2_reg);
            mz3_reg   <= norm_shift({16'd0, mz2_reg}, msb2_reg);
            negx3_reg <= negx2_reg;
            negy3_reg <= negy2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares. Stage 5: sum of squares.
    // ------------------------------------------------------------------
    logic [2*MAG_W-1:0] sqx4_reg, sqy4_reg, sqz4_reg;
    logic [MAG_W-1:0]   mx4_reg, my4_reg, mz4_reg;
    logic               negx4_reg, negy4_reg;
    logic [RAD_W-1:0]   rad5_reg;
    logic [MAG_W-1:0]   mx5_reg, my5_reg, mz5_reg;
    logic               negx5_reg, negy5_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            sqx4_reg  <= mx3_reg * mx3_reg;
            sqy4_reg  <= my3_reg * my3_reg;
            sqz4_reg  <= mz3_reg * mz3_reg;
            mx4_reg   <= mx3_reg;
            my4_reg   <= my3_reg;
            mz4_reg   <= mz3_reg;
            negx4_reg <= negx3_reg;
            negy4_reg <= negy3_reg;

            rad5_reg  <= RAD_W'(sqx4_reg) + RAD_W'(sqy4_reg) + RAD_W'(sqz4_reg);
            mx5_reg   <= mx4_reg;
            my5_reg   <= my4_reg;
            mz5_reg   <= mz4_reg;
            negx5_reg <= negx4_reg;
            negy5_reg <= negy4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the vector length squared, with the magnitudes and
    // signs carried alongside in a matching delay line.
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] root;
    logic [MAG_W-1:0]  mxd_reg [SQ_LAT];
    logic [MAG_W-1:0]  myd_reg [SQ_LAT];
    logic [MAG_W-1:0]  mzd_reg [SQ_LAT];
    logic [1:0]        sgn_sq_reg [SQ_LAT];

    htn_sqrt u_sqrt (
        .aclk     (aclk),
        .ce       (ce),
        .rad_in   (rad5_reg),
        .root_out (root)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            mxd_reg[0]    <= mx5_reg;
            myd_reg[0]    <= my5_reg;
            mzd_reg[0]    <= mz5_reg;
            sgn_sq_reg[0] <= {negx5_reg, negy5_reg};
            for (int k = 1; k < SQ_LAT; k++) begin
                mxd_reg[k]    <= mxd_reg[k-1];
                myd_reg[k]    <= myd_reg[k-1];
                mzd_reg[k]    <= mzd_reg[k-1];
                sgn_sq_reg[k] <= sgn_sq_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Numerator stage. Rounding to nearest and the floor or ceiling for
    // either sign fold into one form: q = (65536*|c| + m - neg) / (2m),
    // then the colour is 32768 + q, or 32768 - q for a negative component.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] numx_reg, numy_reg, numz_reg;
    logic [DEN_W-1:0] den_reg;
    logic [1:0]       sgn_num_reg;
    logic             negx_q, negy_q;

    assign negx_q = sgn_sq_reg[SQ_LAT-1][1];
    assign negy_q = sgn_sq_reg[SQ_LAT-1][0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            numx_reg    <= {1'b0, mxd_reg[SQ_LAT-1], 16'd0} + NUM_W'(root)
                         - NUM_W'(negx_q);
            numy_reg    <= {1'b0, myd_reg[SQ_LAT-1], 16'd0} + NUM_W'(root)
                         - NUM_W'(negy_q);
            numz_reg    <= {1'b0, mzd_reg[SQ_LAT-1], 16'd0} + NUM_W'(root);
            den_reg     <= {root, 1'b0};
            sgn_num_reg <= sgn_sq_reg[SQ_LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // Three divider lanes, signs delayed to match.
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] qx, qy, qz;
    logic [1:0]       sgn_dv_reg [DV_LAT];

    htn_div u_div_x (.aclk(aclk), .ce(ce), .num_in(numx_reg), .den_in(den_reg), .quo_out(qx));
    htn_div u_div_y (.aclk(aclk), .ce(ce), .num_in(numy_reg), .den_in(den_reg), .quo_out(qy));
    htn_div u_div_z (.aclk(aclk), .ce(ce), .num_in(numz_reg), .den_in(den_reg), .quo_out(qz));

    always_ff @(posedge aclk) begin
        if (ce) begin
            sgn_dv_reg[0] <= sgn_num_reg;
            for (int k = 1; k < DV_LAT; k++) begin
                sgn_dv_reg[k] <= sgn_dv_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Colour mapping and output register. A full-scale positive component
    // would reach 65536 and is saturated to 65535.
    // ------------------------------------------------------------------
    function automatic logic [15:0] to_color(input logic neg, input logic [QUO_W-1:0] q);
        logic [16:0] sum;
        begin
            if (neg) begin
                sum = 17'd32768 - {1'b0, q};
            end else begin
                sum = 17'd32768 + {1'b0, q};
            end
            return sum[16] ? 16'hFFFF : sum[15:0];
        end
    endfunction

    logic        m_valid_reg;
    logic [15:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce && v_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce && v_last) begin
            red_reg   <= to_color(sgn_dv_reg[DV_LAT-1][1], qx);
            green_reg <= to_color(1'b0, qz);
            blue_reg  <= to_color(sgn_dv_reg[DV_LAT-1][0], qy);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_normal_red   = red_reg;
    assign m_normal_green = green_reg;
    assign m_normal_blue  = blue_reg;

`ifndef NO_ASSERTIONS
    // The z component is the positive spacing, so green never falls below half.
    a_green_upper_half: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_green[15])
        else $error("green channel below mid-scale");

    // After normalisation the radicand is at least 2^60, so the root has
    // one of its top two bits set.
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[V_SQ] |-> (root[ROOT_W-1:ROOT_W-2] != 2'b00))
        else $error("square root out of normalised range");

    // Normalised magnitudes put the largest component's top bit at 30.
    a_norm_msb: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> (mx3_reg[MAG_W-1] || my3_reg[MAG_W-1] || mz3_reg[MAG_W-1]))
        else $error("normalising shift missed the target position");

    // A numerator stage item always carries a non-zero denominator.
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[V_NUM] |-> (den_reg != '0))
        else $error("zero divider denominator");

    // A result can only be loaded from a valid last stage.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid ##1 m_valid |-> $past(v_last))
        else $error("output loaded without a valid pipeline item");
`endif

endmodule

FILE: test/tb_height_to_normal_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height to normal map testbench
// Drives random and edge-case pixels with random idling on both channels and
// compares every returned colour against a fixed-point normal predictor.
// ----------------------------------------------------------------------------

// Holds the predicted colours of accepted pixels and checks returned ones.
class normal_scoreboard;
    logic [15:0] exp_red[$];
    logic [15:0] exp_green[$];
    logic [15:0] exp_blue[$];
    int          errors;
    int          checked;

    function automatic logic [15:0] channel(bit neg, logic [63:0] mag, logic [63:0] root);
        longint scaled;
        longint num;
        longint den;
        longint q;
        longint r;
        scaled = longint'(mag << 16);
        num    = longint'(root) + (neg ? -scaled : scaled);
        den    = 2 * longint'(root);
        if (num >= 0) q = num / den;
        else          q = -((-num + den - 1) / den);
        r = 32768 + q;
        if (r < 0)     r = 0;
        if (r > 65535) r = 65535;
        return r[15:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Notes an accepted pixel and queues its predicted colour.
    function void note_pixel(logic [31:0] hc, logic [31:0] hh, logic [31:0] hv,
                             bit last_col, bit last_row, logic [16:0] spacing);
        longint      dx;
        longint      dy;
        logic [63:0] mx, my, mz, big, root;
        bit          nx, ny;
        dx = longint'($signed(hh)) - longint'($signed(hc));
        dy = longint'($signed(hv)) - longint'($signed(hc));
        nx = last_col ? (dx < 0) : (dx > 0);
        ny = last_row ? (dy < 0) : (dy > 0);
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        mz = (spacing == 0) ? 64'd1 : 64'(spacing);
        big = mx;
        if (my > big) big = my;
        if (mz > big) big = mz;
        while (big >= (64'd1 << 31)) begin
            mx = mx >> 1; my = my >> 1; mz = mz >> 1; big = big >> 1;
        end
        while (big < (64'd1 << 30)) begin
            mx = mx << 1; my = my << 1; mz = mz << 1; big = big << 1;
        end
        root = int_sqrt(mx * mx + my * my + mz * mz);
        exp_red.push_back(channel(nx, mx, root));
        exp_green.push_back(channel(1'b0, mz, root));
        exp_blue.push_back(channel(!ny && my != 0, my, root));
    endfunction

    // Compares one returned colour with the oldest prediction.
    function void check_colour(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        logic [15:0] er, eg, eb;
        if (exp_red.size() == 0) begin
            $display("%0t: unexpected result %h %h %h", $time, r, g, b);
            errors++;
            return;
        end
        er = exp_red.pop_front();
        eg = exp_green.pop_front();
        eb = exp_blue.pop_front();
        checked++;
        if (r !== er) begin
            $display("%0t: red expected %h actual %h", $time, er, r);
            errors++;
        end
        if (g !== eg) begin
            $display("%0t: green expected %h actual %h", $time, eg, g);
            errors++;
        end
        if (b !== eb) begin
            $display("%0t: blue expected %h actual %h", $time, eb, b);
            errors++;
        end
    endfunction
endclass

module tb_height_to_normal_map;

    localparam int LATENCY = 55;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [16:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_height_center;
    logic [31:0] s_height_horizontal;
    logic [31:0] s_height_vertical;
    logic        s_at_last_column;
    logic        s_at_last_row;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_normal_red;
    logic [15:0] m_normal_green;
    logic [15:0] m_normal_blue;

    normal_scoreboard colours;
    // Spacing the block currently holds, mirrored for the predictor.
    logic [16:0] spacing;
    // When set, neither side idles; this gives a long back-to-back stretch.
    bit          busy_stretch;
    int          pixels_sent;

    height_to_normal_map u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_height_center    (s_height_center),
        .s_height_horizontal(s_height_horizontal),
        .s_height_vertical  (s_height_vertical),
        .s_at_last_column   (s_at_last_column),
        .s_at_last_row      (s_at_last_row),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_normal_red       (m_normal_red),
        .m_normal_green     (m_normal_green),
        .m_normal_blue      (m_normal_blue)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legitimate run.
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // The receiver stalls about 36 percent of the time, except in the busy stretch.
    // Every transaction that completes at a rising edge is checked there too.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                colours.check_colour(m_normal_red, m_normal_green, m_normal_blue);
            m_ready <= busy_stretch || ($urandom_range(99) >= 36);
        end
    end

    // Presents one pixel and holds it until the transaction completes. A random
    // gap before it lands idle cycles on every stage of the pipeline. Valid is
    // left high afterwards; the next pixel, an idle cycle or the caller drops it.
    task automatic send_pixel(logic [31:0] hc, logic [31:0] hh, logic [31:0] hv,
                              bit last_col, bit last_row);
        while (!busy_stretch && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_height_center     <= hc;
        s_height_horizontal <= hh;
        s_height_vertical   <= hv;
        s_at_last_column    <= last_col;
        s_at_last_row       <= last_row;
        do @(posedge aclk); while (!s_ready);
        colours.note_pixel(hc, hh, hv, last_col, last_row, spacing);
        pixels_sent++;
    endtask

    // Lets the pipeline drain completely, then writes the grid spacing.
    task automatic set_spacing(logic [16:0] value);
        s_valid <= 1'b0;
        while (colours.exp_red.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        spacing = value;
    endtask

    // Random heights: mostly a gentle slope around the centre, sometimes
    // anything the 32-bit fields allow.
    task automatic send_random_pixel();
        logic [31:0] hc, hh, hv;
        hc = $urandom;
        if ($urandom_range(3) == 0) begin
            hh = $urandom;
            hv = $urandom;
        end else begin
            hc = {{8{hc[31]}}, hc[23:0]};
            hh = hc + {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
            hv = hc + {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
        end
        send_pixel(hc, hh, hv, $urandom_range(1), $urandom_range(1));
    endtask

    initial begin
        logic [16:0] spacings[5];
        colours        = new();
        spacing        = 17'd128;
        busy_stretch   = 1'b0;
        pixels_sent    = 0;
        aresetn             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        s_valid             <= 1'b0;
        s_height_center     <= '0;
        s_height_horizontal <= '0;
        s_height_vertical   <= '0;
        s_at_last_column    <= 1'b0;
        s_at_last_row       <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pixels at the reset spacing: flat ground, extreme heights,
        // every combination of edge fallbacks.
        send_pixel(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_pixel(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0);
        send_pixel(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
        send_pixel(32'h0, 32'h0001_0000, 32'hffff_0000, 1'b1, 1'b0);
        send_pixel(32'h0, 32'hffff_0000, 32'h0001_0000, 1'b0, 1'b1);
        send_pixel(32'h1234_5678, 32'h1234_5678, 32'h1234_5679, 1'b0, 1'b0);
        send_pixel(32'h0, 32'h7fff_ffff, 32'h0, 1'b1, 1'b0);
        send_pixel(32'h0, 32'h0, 32'h8000_0000, 1'b0, 1'b1);

        // Zero spacing is treated as one; flat ground then gives a full-scale
        // green channel.
        set_spacing(17'd0);
        send_pixel(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_pixel(32'h0, 32'h1, 32'hffff_ffff, 1'b1, 1'b1);
        send_pixel(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0, 1'b0);
        // Largest spacing, beyond the nominal 65536.
        set_spacing(17'h1ffff);
        send_pixel(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_pixel(32'h0, 32'h0000_0001, 32'h0001_ffff, 1'b1, 1'b0);
        send_pixel(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1);

        // Random pixels across several spacings, the extremes among them.
        spacings = '{17'd1, 17'd65536, 17'd128, 17'd2, 17'd0};
        foreach (spacings[i]) begin
            set_spacing(i == 4 ? 17'($urandom) : spacings[i]);
            busy_stretch = (i == 2);
            repeat (88) send_random_pixel();
            busy_stretch = 1'b0;
        end

        s_valid <= 1'b0;
        while (colours.exp_red.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Covered %0d pixels over several spacings, edge flags and idling;",
                 pixels_sent);
        $display("%0d colours compared, %0d mismatches.", colours.checked, colours.errors);
        if (colours.errors == 0 && colours.exp_red.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
